// File: rtl/imufd_pkg.sv
// Package: constants and kind decode for the inertial sensor frame deframer.
package imufd_pkg;

  localparam logic [7:0] HDR_BYTE   = 8'h55;
  localparam logic [7:0] KB_TIME    = 8'h50;
  localparam logic [7:0] KB_ACCEL   = 8'h51;
  localparam logic [7:0] KB_GYRO    = 8'h52;
  localparam logic [7:0] KB_ANGLE   = 8'h53;
  localparam logic [7:0] KB_QUAT    = 8'h59;

  localparam logic [2:0] KIND_TIME  = 3'd0;
  localparam logic [2:0] KIND_ACCEL = 3'd1;
  localparam logic [2:0] KIND_GYRO  = 3'd2;
  localparam logic [2:0] KIND_ANGLE = 3'd3;
  localparam logic [2:0] KIND_QUAT  = 3'd4;

  localparam int unsigned PAYLOAD_LEN = 8;
  localparam int unsigned STORE_DEPTH = PAYLOAD_LEN - 1;

  typedef struct packed {
    logic       ok;
    logic [2:0] kind;
  } kind_dec_t;

  function automatic kind_dec_t decode_kind(input logic [7:0] b);
    kind_dec_t d;
    d.ok   = 1'b1;
    d.kind = KIND_TIME;
    case (b)
      KB_TIME:  d.kind = KIND_TIME;
      KB_ACCEL: d.kind = KIND_ACCEL;
      KB_GYRO:  d.kind = KIND_GYRO;
      KB_ANGLE: d.kind = KIND_ANGLE;
      KB_QUAT:  d.kind = KIND_QUAT;
      default:  d.ok   = 1'b0;
    endcase
    return d;
  endfunction

endpackage

// File: rtl/imu_frame_deframer_top.sv
// Top level: byte-serial inertial sensor frame deframer with registered result.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------
//  in_     | in  | in_tvalid/tready   | tdata[7:0] rx_byte
//  out_    | out | out_tvalid/tready  | tuser[2:0] frame_kind,
//          |     |                    | tdata[63:0] word_a..word_d
//
// One byte per cycle; the decoded frame appears in the result register the
// cycle after its eighth payload byte. in_tready drops only while a result is
// held and out_tready is low. Synchronous active-low reset returns the parser
// to header hunt and empties the result register; payload bytes need no reset.
module imu_frame_deframer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [2:0]  out_tuser,  // [2:0] frame_kind
  output logic [63:0] out_tdata   // [15:0] word_a, [31:16] word_b,
                                  // [47:32] word_c, [63:48] word_d
);
  import imufd_pkg::*;

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_KIND = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;
  localparam logic [1:0] PH_SUM  = 2'd3;

  logic [1:0]  phase_r, phase_nxt;
  logic [2:0]  count_r, count_nxt;
  logic [2:0]  kind_r, kind_nxt;
  logic [7:0]  store_r [STORE_DEPTH];
  logic        ovalid_r, ovalid_nxt;
  logic [2:0]  okind_r;
  logic [63:0] odata_r;
  logic        in_fire;
  logic        store_we;
  logic        emit;
  kind_dec_t   kd;

  assign in_tready = !ovalid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign kd        = decode_kind(in_tdata);

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    kind_nxt  = kind_r;
    store_we  = 1'b0;
    emit      = 1'b0;
    if (in_fire) begin
      case (phase_r)
        PH_HUNT: begin
          if (in_tdata == HDR_BYTE) phase_nxt = PH_KIND;
        end
        PH_KIND: begin
          if (kd.ok) begin
            kind_nxt  = kd.kind;
            count_nxt = 3'd0;
            phase_nxt = PH_DATA;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
        PH_DATA: begin
          if (count_r != 3'(STORE_DEPTH)) begin
            store_we  = 1'b1;
            count_nxt = count_r + 3'd1;
          end else begin
            emit      = 1'b1;
            count_nxt = 3'd0;
            phase_nxt = PH_SUM;
          end
        end
        default: phase_nxt = PH_HUNT;
      endcase
    end
    ovalid_nxt = emit || (ovalid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      count_r  <= 3'd0;
      kind_r   <= KIND_TIME;
      ovalid_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      kind_r   <= kind_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) store_r[count_r] <= in_tdata;
  end

  // little-endian words; last payload byte goes straight to word_d
  always_ff @(posedge clk) begin
    if (emit) begin
      okind_r <= kind_r;
      odata_r <= {in_tdata, store_r[6], store_r[5], store_r[4],
                  store_r[3], store_r[2], store_r[1], store_r[0]};
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tuser  = okind_r;
  assign out_tdata  = odata_r;

  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && phase_r == PH_DATA && count_r == 3'(STORE_DEPTH)) |=> out_tvalid)
    else $error("final payload beat did not raise a result");

  a_sum_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SUM) |-> (count_r == 3'd0))
    else $error("payload count not cleared at checksum");

  a_sum_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && phase_r == PH_SUM) |=> (phase_r == PH_HUNT && !$rose(out_tvalid)))
    else $error("checksum beat did not return to hunt");

  a_rise_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_fire && phase_r == PH_DATA))
    else $error("result raised outside payload phase");

endmodule

// File: dv/imu_frame_deframer_top_test.sv
// Self-checking bench: feeds sensor byte streams to the deframer and checks each decoded frame.
`timescale 1ns / 100ps

module imu_frame_deframer_top_test;
  import imufd_pkg::*;

  typedef enum logic [1:0] {PH_HUNT, PH_KIND, PH_DATA, PH_SUM} parse_phase_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
    logic [15:0] d;
  } imu_frame_t;

  typedef struct {
    logic [7:0] b;
    bit         wait_idle;
  } rx_beat_t;

  localparam int N_ITEMS = 1650;
  localparam int HOLD_AT = 500;
  localparam int DRAIN_AT = 900;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [2:0]  out_tuser;
  logic [63:0] out_tdata;

  rx_beat_t     rx_stream [$];
  imu_frame_t   frames_due [$];

  parse_phase_e phase = PH_HUNT;
  logic [2:0]   n_stored = 3'd0;
  logic [2:0]   kind_now = KIND_TIME;
  logic [7:0]   payload_bytes [7];

  int mismatches = 0;
  int beats_in = 0;
  bit in_taken = 1'b0;
  bit tx_burst = 1'b0;
  int tx_gap = 0;
  bit rx_calm = 1'b0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  imu_frame_deframer_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  task automatic deframe_byte(input logic [7:0] rx);
    imu_frame_t f;
    case (phase)
      PH_HUNT: begin
        if (rx == HDR_BYTE) phase = PH_KIND;
      end
      PH_KIND: begin
        phase = PH_DATA;
        n_stored = 3'd0;
        case (rx)
          KB_TIME:  kind_now = KIND_TIME;
          KB_ACCEL: kind_now = KIND_ACCEL;
          KB_GYRO:  kind_now = KIND_GYRO;
          KB_ANGLE: kind_now = KIND_ANGLE;
          KB_QUAT:  kind_now = KIND_QUAT;
          default:  phase = PH_HUNT;
        endcase
      end
      PH_DATA: begin
        if (n_stored < 3'd7) begin
          payload_bytes[n_stored] = rx;
          n_stored++;
        end else begin
          f.kind = kind_now;
          f.a = {payload_bytes[1], payload_bytes[0]};
          f.b = {payload_bytes[3], payload_bytes[2]};
          f.c = {payload_bytes[5], payload_bytes[4]};
          f.d = {rx, payload_bytes[6]};
          frames_due.push_back(f);
          n_stored = 3'd0;
          phase = PH_SUM;
        end
      end
      default: phase = PH_HUNT;
    endcase
  endtask

  task automatic note_mismatch(input string what, input imu_frame_t want, input imu_frame_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected kind %0d words %0d %0d %0d %0d, got kind %0d words %0d %0d %0d %0d",
               $time, what, want.kind, $signed(want.a), $signed(want.b), $signed(want.c),
               $signed(want.d), got.kind, $signed(got.a), $signed(got.b), $signed(got.c),
               $signed(got.d));
  endtask

  task automatic push_byte(input logic [7:0] rx);
    rx_beat_t item;
    item.b = rx;
    item.wait_idle = 1'b0;
    rx_stream.push_back(item);
  endtask

  // sample both channels at the rising edge
  always @(posedge clk) begin
    imu_frame_t got;
    imu_frame_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.kind = out_tuser;
        got.a = out_tdata[15:0];
        got.b = out_tdata[31:16];
        got.c = out_tdata[47:32];
        got.d = out_tdata[63:48];
        if (frames_due.size() == 0) begin
          want = '0;
          note_mismatch("unexpected frame", want, got);
        end else begin
          want = frames_due.pop_front();
          if (got !== want) note_mismatch("frame mismatch", want, got);
        end
      end
      if (in_tvalid && in_tready) begin
        deframe_byte(in_tdata);
        beats_in++;
        in_taken = 1'b1;
      end
    end
  end

  // byte driver
  always @(negedge clk) begin
    logic       nxt_valid;
    logic [7:0] nxt_data;
    int         r;
    nxt_valid = in_tvalid;
    nxt_data  = in_tdata;
    if (rst_n && (in_taken || !in_tvalid)) begin
      if (in_taken) begin
        in_taken = 1'b0;
        if ($urandom_range(0, 99) == 0) tx_burst = !tx_burst;
        if (!tx_burst) begin
          r = $urandom_range(0, 99);
          if (r < 55) tx_gap = 0;
          else if (r < 90) tx_gap = $urandom_range(1, 3);
          else tx_gap = $urandom_range(4, 30);
        end
      end
      nxt_valid = 1'b0;
      if (tx_gap > 0) begin
        tx_gap--;
      end else if (rx_stream.size() > 0 &&
                   !(rx_stream[0].wait_idle && frames_due.size() > 0)) begin
        nxt_valid = 1'b1;
        nxt_data  = rx_stream[0].b;
        void'(rx_stream.pop_front());
      end
    end
    in_tvalid <= nxt_valid;
    in_tdata  <= nxt_data;
  end

  // result receiver, with one long hold-off to back the block up
  always @(negedge clk) begin
    logic nxt_ready;
    nxt_ready = 1'b1;
    if (!hold_done && beats_in >= HOLD_AT) begin
      hold_left = 400;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      nxt_ready = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      nxt_ready = 1'b0;
    end else begin
      if ($urandom_range(0, 149) == 0) rx_calm = !rx_calm;
      if (!rx_calm && $urandom_range(0, 3) == 0) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
        nxt_ready = 1'b0;
      end
    end
    if (!rst_n) nxt_ready = 1'b0;
    out_tready <= nxt_ready;
  end

  initial begin
    logic [7:0] directed [$];
    logic [7:0] kind_codes [5];
    int         r;
    int         n_directed;
    directed = '{8'h00,
                 8'h55, 8'h55, 8'h50,
                 8'h55, 8'h51, 8'h00, 8'h80, 8'hFF, 8'h7F, 8'hFF, 8'hFF, 8'h55, 8'h55,
                 8'h55,
                 8'h55, 8'h7A,
                 8'h55, 8'hFF};
    kind_codes = '{KB_TIME, KB_ACCEL, KB_GYRO, KB_ANGLE, KB_QUAT};
    foreach (directed[i]) push_byte(directed[i]);
    n_directed = rx_stream.size();

    while (rx_stream.size() < N_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        repeat ($urandom_range(0, 2)) push_byte(8'($urandom_range(0, 255)));
        push_byte(HDR_BYTE);
        push_byte(kind_codes[3'($urandom_range(0, 4))]);
        repeat (8) begin
          case ($urandom_range(0, 9))
            0: push_byte(8'h00);
            1: push_byte(8'hFF);
            2: push_byte($urandom_range(0, 1) ? 8'h80 : 8'h7F);
            3: push_byte(HDR_BYTE);
            default: push_byte(8'($urandom_range(0, 255)));
          endcase
        end
        push_byte(8'($urandom_range(0, 255)));
      end else if (r < 90) begin
        // usually a broken frame: random kind, then zero to nine random bytes
        push_byte(HDR_BYTE);
        push_byte(8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 9)) push_byte(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
      end
    end
    rx_stream[n_directed].wait_idle = 1'b1;
    rx_stream[DRAIN_AT].wait_idle = 1'b1;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (rx_stream.size() != 0 || in_tvalid) @(posedge clk);
    while (frames_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && frames_due.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
